// ----- hw/rtl/iec61937_burst_framer_macros.svh -----
// assertion macros for the burst framer
`ifndef IEC61937_BURST_FRAMER_MACROS_SVH
`define IEC61937_BURST_FRAMER_MACROS_SVH

// same-cycle implication, checked out of reset
`define IBF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("burst framer check failed");

// next-cycle implication, checked out of reset
`define IBF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("burst framer check failed");

`endif

// ----- hw/rtl/ibf_pkg.sv -----
// shared types and constants of the burst framer
package ibf_pkg;

  localparam logic [15:0] SYNCWORD1         = 16'hF872;
  localparam logic [15:0] SYNCWORD2         = 16'h4E1F;
  localparam logic [15:0] PREAMBLE_BYTES    = 16'd8;
  localparam int          HDR_WORDS         = 4;
  localparam int          HDR_IDX_W         = $clog2(HDR_WORDS);
  localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(HDR_WORDS - 1);
  localparam logic [HDR_IDX_W-1:0] HDR_STEP = HDR_IDX_W'(1);

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_FILL = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOCFG  = 2'd1;
  localparam logic [1:0] ST_LONG   = 2'd2;
  localparam logic [1:0] ST_UNEXP  = 2'd3;

  localparam logic [2:0] CFG_REP_BYTES = 3'd0;
  localparam logic [2:0] CFG_USE_PRE   = 3'd1;
  localparam logic [2:0] CFG_SWAP      = 3'd2;
  localparam logic [2:0] CFG_INFO      = 3'd3;
  localparam logic [2:0] CFG_LENGTH    = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_PAD     = 3'b100
  } phase_e;

  typedef struct packed {
    logic       opcode;
    logic [7:0] payload_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_word;
    logic        last_of_burst;
    logic [1:0]  status;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [15:0] period_bytes;
    logic        preamble_en;
    logic        swap_bytes;
    logic [15:0] burst_info;
    logic [15:0] burst_length;
  } cfg_t;

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  held_byte;
    logic        holding;
    logic [15:0] bytes_placed;
    logic        frame_error;
  } frame_t;

  // results caused by one input: optional header words, then optional final word
  typedef struct packed {
    logic        pre;
    logic        fin;
    logic [15:0] word;
    logic        lob;
    logic [1:0]  status;
  } bundle_t;

  function automatic frame_t go_idle(frame_t f);
    frame_t r;
    r              = f;
    r.phase        = PH_IDLE;
    r.holding      = 1'b0;
    r.bytes_placed = 16'd0;
    r.frame_error  = 1'b0;
    return r;
  endfunction

endpackage

// ----- hw/rtl/ibf_step.sv -----
// next frame state and result bundle for one input byte or fill request
module ibf_step (
  input  ibf_pkg::cfg_t     cfg_i,
  input  ibf_pkg::frame_t   frame_i,
  input  ibf_pkg::in_item_t item_i,
  output ibf_pkg::frame_t   frame_o,
  output ibf_pkg::bundle_t  bundle_o
);

  logic [15:0] lim;
  logic [16:0] lim_x;
  logic [16:0] bp_sum;
  logic [16:0] need;
  logic        ok;
  logic        emitted;
  logic [15:0] word;

  assign lim   = {cfg_i.period_bytes[15:1], 1'b0};
  assign lim_x = {1'b0, lim};

  always_comb begin
    frame_o         = frame_i;
    bundle_o        = '0;
    bundle_o.status = ibf_pkg::ST_OK;
    ok              = 1'b1;
    emitted         = 1'b0;
    word            = 16'd0;
    bp_sum          = {1'b0, frame_i.bytes_placed} + 17'd2;
    need            = cfg_i.preamble_en ? (17'(ibf_pkg::PREAMBLE_BYTES) + 17'd2) : 17'd2;

    if (lim == 16'd0) begin
      bundle_o.fin    = 1'b1;
      bundle_o.status = ibf_pkg::ST_NOCFG;
    end else if (item_i.opcode == ibf_pkg::OP_FILL) begin
      bundle_o.fin = 1'b1;
      if (frame_i.phase == ibf_pkg::PH_PAD && !frame_i.frame_error) begin
        if (bp_sum >= lim_x) begin
          bundle_o.lob = 1'b1;
          frame_o      = ibf_pkg::go_idle(frame_i);
        end else begin
          frame_o.bytes_placed = bp_sum[15:0];
        end
      end else begin
        bundle_o.status = ibf_pkg::ST_UNEXP;
      end
    end else if (frame_i.phase == ibf_pkg::PH_PAD) begin
      bundle_o.fin    = 1'b1;
      bundle_o.status = ibf_pkg::ST_LONG;
    end else if (frame_i.phase == ibf_pkg::PH_PAYLOAD && frame_i.frame_error) begin
      bundle_o.fin    = 1'b1;
      bundle_o.status = ibf_pkg::ST_LONG;
      if (item_i.last_byte) begin
        frame_o = ibf_pkg::go_idle(frame_i);
      end
    end else begin
      // frame start: the header, if enabled, plus first word must fit in the period
      if (frame_i.phase != ibf_pkg::PH_PAYLOAD) begin
        if (need > lim_x) begin
          ok = 1'b0;
        end else begin
          frame_o       = ibf_pkg::go_idle(frame_i);
          frame_o.phase = ibf_pkg::PH_PAYLOAD;
          if (cfg_i.preamble_en) begin
            bundle_o.pre         = 1'b1;
            frame_o.bytes_placed = ibf_pkg::PREAMBLE_BYTES;
          end
        end
      end else if (!frame_i.holding && bp_sum > lim_x) begin
        ok = 1'b0;
      end

      if (!ok) begin
        bundle_o.fin    = 1'b1;
        bundle_o.status = ibf_pkg::ST_LONG;
        if (item_i.last_byte) begin
          frame_o = ibf_pkg::go_idle(frame_i);
        end else begin
          frame_o.phase       = ibf_pkg::PH_PAYLOAD;
          frame_o.holding     = 1'b0;
          frame_o.frame_error = 1'b1;
        end
      end else begin
        if (!frame_o.holding) begin
          frame_o.bytes_placed = frame_o.bytes_placed + 16'd2;
          if (item_i.last_byte) begin
            word    = {8'h00, item_i.payload_byte};
            emitted = 1'b1;
          end else begin
            frame_o.held_byte = item_i.payload_byte;
            frame_o.holding   = 1'b1;
          end
        end else begin
          word = cfg_i.swap_bytes ? {item_i.payload_byte, frame_o.held_byte}
                                  : {frame_o.held_byte, item_i.payload_byte};
          frame_o.holding = 1'b0;
          emitted         = 1'b1;
        end

        if (emitted) begin
          bundle_o.fin  = 1'b1;
          bundle_o.word = word;
          if (item_i.last_byte && frame_o.bytes_placed >= lim) begin
            bundle_o.lob = 1'b1;
            frame_o      = ibf_pkg::go_idle(frame_o);
          end else if (item_i.last_byte) begin
            frame_o.phase = ibf_pkg::PH_PAD;
          end
        end
      end
    end
  end

endmodule

// ----- hw/rtl/iec61937_burst_framer.sv -----
// burst framer top level: config registers, frame state and result register
//
//   channel   direction  handshake                  payload
//   in        in         in_valid_i / in_stall_o    in_item_i  (ibf_pkg::in_item_t)
//   out       out        out_valid_o / out_stall_i  out_item_o (ibf_pkg::out_item_t)
//   cfg       in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// one input per cycle unless stalled; an input causes 0, 1, 4 or 5 results, one transfer each
// a new input is taken in the cycle the last result of the previous one leaves
// the result register holds the header count and final word, so results leave
// one per cycle unless stalled; a held byte with no header gives no result and frees the input at once
// reset is asynchronous; after it the block is idle and unconfigured
module iec61937_burst_framer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ibf_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ibf_pkg::out_item_t  out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);

  ibf_pkg::cfg_t    cfg_q;
  ibf_pkg::frame_t  frame_q;
  ibf_pkg::frame_t  frame_d;
  ibf_pkg::bundle_t bundle_d;

  logic                          pre_q;
  logic                          fin_q;
  logic [ibf_pkg::HDR_IDX_W-1:0] idx_q;
  logic [15:0]                   word_q;
  logic                          lob_q;
  logic [1:0]                    st_q;
  logic [15:0]                   hdr_word;

  logic in_xfer;
  logic out_xfer;
  logic drain;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period_bytes <= 16'd0;
      cfg_q.preamble_en  <= 1'b1;
      cfg_q.swap_bytes   <= 1'b1;
      cfg_q.burst_info   <= 16'd0;
      cfg_q.burst_length <= 16'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ibf_pkg::CFG_REP_BYTES: cfg_q.period_bytes <= cfg_data_i;
        ibf_pkg::CFG_USE_PRE:   cfg_q.preamble_en  <= cfg_data_i[0];
        ibf_pkg::CFG_SWAP:      cfg_q.swap_bytes   <= cfg_data_i[0];
        ibf_pkg::CFG_INFO:      cfg_q.burst_info   <= cfg_data_i;
        ibf_pkg::CFG_LENGTH:    cfg_q.burst_length <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ibf_step u_step (
    .cfg_i    (cfg_q),
    .frame_i  (frame_q),
    .item_i   (in_item_i),
    .frame_o  (frame_d),
    .bundle_o (bundle_d)
  );

  always_comb begin
    case (idx_q)
      2'd0:    hdr_word = ibf_pkg::SYNCWORD1;
      2'd1:    hdr_word = ibf_pkg::SYNCWORD2;
      2'd2:    hdr_word = cfg_q.burst_info;
      2'd3:    hdr_word = cfg_q.burst_length;
      default: hdr_word = 16'd0;
    endcase
  end

  assign out_valid_o = pre_q || fin_q;

  always_comb begin
    out_item_o.out_word      = pre_q ? hdr_word : word_q;
    out_item_o.last_of_burst = pre_q ? 1'b0 : lob_q;
    out_item_o.status        = pre_q ? ibf_pkg::ST_OK : st_q;
    out_item_o.last_of_run   = pre_q ? (idx_q == ibf_pkg::HDR_LAST && !fin_q) : 1'b1;
  end

  assign out_xfer   = out_valid_o && !out_stall_i;
  assign drain      = out_xfer && out_item_o.last_of_run;
  assign in_stall_o = out_valid_o && !drain;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= ibf_pkg::go_idle('{phase: ibf_pkg::PH_IDLE, default: '0});
    end else if (in_xfer) begin
      frame_q <= frame_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q <= 1'b0;
      fin_q <= 1'b0;
      idx_q <= '0;
    end else if (in_xfer) begin
      pre_q <= bundle_d.pre;
      fin_q <= bundle_d.fin;
      idx_q <= '0;
    end else if (out_xfer) begin
      if (pre_q) begin
        // header words first, then the final word if there is one
        if (idx_q == ibf_pkg::HDR_LAST) begin
          pre_q <= 1'b0;
        end else begin
          idx_q <= idx_q + ibf_pkg::HDR_STEP;
        end
      end else begin
        fin_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      word_q <= bundle_d.word;
      lob_q  <= bundle_d.lob;
      st_q   <= bundle_d.status;
    end
  end

  `include "iec61937_burst_framer_macros.svh"

  `IBF_ASSERT_IMPL(a_empty_takes_input, clk_i, rst_ni, !out_valid_o, !in_stall_o)
  `IBF_ASSERT_IMPL(a_error_word_zero, clk_i, rst_ni,
                   out_valid_o && out_item_o.status != ibf_pkg::ST_OK,
                   out_item_o.out_word == 16'd0)
  `IBF_ASSERT_NEXT(a_run_continues, clk_i, rst_ni, out_xfer && !out_item_o.last_of_run, out_valid_o)

endmodule

// ----- tb/burst_framer_checker.sv -----
// burst framer checker: tracks config and frame state, predicts words, compares output
`timescale 1ns / 1ps
module burst_framer_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  ibf_pkg::in_item_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  ibf_pkg::out_item_t out_item_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output int                 fail_count_o,
  output int                 outstanding_o,
  output int                 checked_o
);

  ibf_pkg::cfg_t      regs;
  ibf_pkg::phase_e    phase;
  logic [7:0]         held;
  logic               holding;
  logic [15:0]        placed;
  logic               frame_err;
  ibf_pkg::out_item_t expected_words[$];
  int                 fail_count = 0;
  int                 checked = 0;
  int                 outstanding = 0;

  assign fail_count_o  = fail_count;
  assign checked_o     = checked;
  assign outstanding_o = outstanding;

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    fail_count++;
    if (fail_count <= 40) begin
      $display("checker: result %0d %s got %0h want %0h", checked, what, got, want);
    end
  endtask

  task automatic push_word(input logic [15:0] w, input logic lob, input logic [1:0] st);
    expected_words.push_back('{out_word: w, last_of_burst: lob, status: st,
                               last_of_run: 1'b0});
  endtask

  task automatic leave_frame();
    phase     = ibf_pkg::PH_IDLE;
    holding   = 1'b0;
    placed    = 16'd0;
    frame_err = 1'b0;
  endtask

  // expected words for one accepted input
  task automatic frame_step(input ibf_pkg::in_item_t it);
    int                 lim;
    int                 need;
    int                 nb;
    int                 base;
    logic               ok;
    logic               emitted;
    logic [15:0]        w;
    ibf_pkg::out_item_t tail;
    base = expected_words.size();
    lim  = int'(regs.period_bytes & 16'hFFFE);
    if (lim == 0) begin
      push_word(16'h0, 1'b0, ibf_pkg::ST_NOCFG);
    end else if (it.opcode == ibf_pkg::OP_FILL) begin
      if (phase == ibf_pkg::PH_PAD && !frame_err) begin
        nb = int'(placed) + 2;
        if (nb >= lim) begin
          push_word(16'h0, 1'b1, ibf_pkg::ST_OK);
          leave_frame();
        end else begin
          placed = 16'(nb);
          push_word(16'h0, 1'b0, ibf_pkg::ST_OK);
        end
      end else begin
        push_word(16'h0, 1'b0, ibf_pkg::ST_UNEXP);
      end
    end else if (phase == ibf_pkg::PH_PAD) begin
      push_word(16'h0, 1'b0, ibf_pkg::ST_LONG);
    end else if (phase == ibf_pkg::PH_PAYLOAD && frame_err) begin
      push_word(16'h0, 1'b0, ibf_pkg::ST_LONG);
      if (it.last_byte) leave_frame();
    end else begin
      ok = 1'b1;
      if (phase != ibf_pkg::PH_PAYLOAD) begin
        need = (regs.preamble_en ? int'(ibf_pkg::PREAMBLE_BYTES) : 0) + 2;
        if (need > lim) begin
          ok = 1'b0;
        end else begin
          leave_frame();
          phase = ibf_pkg::PH_PAYLOAD;
          if (regs.preamble_en) begin
            push_word(ibf_pkg::SYNCWORD1, 1'b0, ibf_pkg::ST_OK);
            push_word(ibf_pkg::SYNCWORD2, 1'b0, ibf_pkg::ST_OK);
            push_word(regs.burst_info, 1'b0, ibf_pkg::ST_OK);
            push_word(regs.burst_length, 1'b0, ibf_pkg::ST_OK);
            placed = ibf_pkg::PREAMBLE_BYTES;
          end
        end
      end else if (!holding && int'(placed) + 2 > lim) begin
        ok = 1'b0;
      end
      if (!ok) begin
        push_word(16'h0, 1'b0, ibf_pkg::ST_LONG);
        if (it.last_byte) begin
          leave_frame();
        end else begin
          phase     = ibf_pkg::PH_PAYLOAD;
          holding   = 1'b0;
          frame_err = 1'b1;
        end
      end else begin
        emitted = 1'b0;
        w       = 16'h0;
        if (!holding) begin
          placed = placed + 16'd2;
          if (it.last_byte) begin
            w       = {8'h00, it.payload_byte};
            emitted = 1'b1;
          end else begin
            held    = it.payload_byte;
            holding = 1'b1;
          end
        end else begin
          w       = regs.swap_bytes ? {it.payload_byte, held} : {held, it.payload_byte};
          holding = 1'b0;
          emitted = 1'b1;
        end
        if (emitted) begin
          if (it.last_byte && int'(placed) >= lim) begin
            push_word(w, 1'b1, ibf_pkg::ST_OK);
            leave_frame();
          end else begin
            push_word(w, 1'b0, ibf_pkg::ST_OK);
            if (it.last_byte) phase = ibf_pkg::PH_PAD;
          end
        end
      end
    end
    if (expected_words.size() > base) begin
      tail = expected_words.pop_back();
      tail.last_of_run = 1'b1;
      expected_words.push_back(tail);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    ibf_pkg::out_item_t want;
    if (!rst_ni) begin
      regs <= '{period_bytes: 16'd0, preamble_en: 1'b1, swap_bytes: 1'b1,
                burst_info: 16'd0, burst_length: 16'd0};
      held <= 8'h00;
      phase <= ibf_pkg::PH_IDLE;
      holding <= 1'b0;
      placed <= 16'd0;
      frame_err <= 1'b0;
      expected_words.delete();
      outstanding <= 0;
    end else begin
      // compare first so a stray word never matches a word predicted at this edge
      if (out_valid_i && !out_stall_i) begin
        checked++;
        if (expected_words.size() == 0) begin
          report_mismatch("word with nothing pending", out_item_i.out_word, 16'h0);
        end else begin
          want = expected_words.pop_front();
          if (out_item_i.out_word !== want.out_word)
            report_mismatch("out_word", out_item_i.out_word, want.out_word);
          if (out_item_i.last_of_burst !== want.last_of_burst)
            report_mismatch("last_of_burst", 16'(out_item_i.last_of_burst),
                            16'(want.last_of_burst));
          if (out_item_i.status !== want.status)
            report_mismatch("status", 16'(out_item_i.status), 16'(want.status));
          if (out_item_i.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", 16'(out_item_i.last_of_run),
                            16'(want.last_of_run));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          ibf_pkg::CFG_REP_BYTES: regs.period_bytes = cfg_data_i;
          ibf_pkg::CFG_USE_PRE:   regs.preamble_en = cfg_data_i[0];
          ibf_pkg::CFG_SWAP:      regs.swap_bytes = cfg_data_i[0];
          ibf_pkg::CFG_INFO:      regs.burst_info = cfg_data_i;
          ibf_pkg::CFG_LENGTH:    regs.burst_length = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) frame_step(in_item_i);
      outstanding <= expected_words.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
// top of the burst framer testbench: clock, reset, stimulus, output stall and verdict
`timescale 1ns / 1ps
module testbench;

  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 100;

  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PERIODIC} rx_mode_e;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  ibf_pkg::in_item_t  in_item_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  ibf_pkg::out_item_t out_item_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = ibf_pkg::CFG_REP_BYTES;
  logic [15:0]        cfg_data_i  = 16'd0;

  int            fail_count;
  int            outstanding;
  int            checked;
  ibf_pkg::cfg_t cur_cfg;
  int            burst_left   = 0;
  int            items_sent   = 0;
  int            frames_sent  = 0;
  int            reg_writes   = 0;
  int            quiet_cycles = 0;
  logic          hold_req     = 1'b0;
  logic          hold_done    = 1'b0;

  always #6 clk_i = ~clk_i;

  initial begin : reset_gen
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  iec61937_burst_framer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  burst_framer_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .in_item_i     (in_item_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_item_i    (out_item_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding),
    .checked_o     (checked)
  );

  // any transfer on any channel counts as progress
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin : receiver
    rx_mode_e mode;
    int       left;
    int       tick;
    mode = RX_FREE;
    left = 0;
    tick = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
        out_stall_i <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 2));
          left = $urandom_range(16, 64);
        end
        left--;
        tick++;
        case (mode)
          RX_FREE:   out_stall_i <= 1'b0;
          RX_RANDOM: out_stall_i <= ($urandom_range(0, 2) == 0);
          default:   out_stall_i <= (tick % 5 == 1) || (tick % 5 == 3);
        endcase
      end
    end
  end

  task automatic offer_item(input logic op, input logic [7:0] b, input logic lb);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= '{opcode: op, payload_byte: b, last_byte: lb};
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_frame(input int n);
    for (int i = 0; i < n; i++) offer_item(ibf_pkg::OP_BYTE, 8'($urandom), i == n - 1);
    frames_sent++;
  endtask

  // padding requests; a stray byte may slip in before the last one
  task automatic send_fills(input int k, input logic stray);
    for (int j = 0; j < k; j++) begin
      if (stray && j == k - 1) offer_item(ibf_pkg::OP_BYTE, 8'($urandom), 1'($urandom));
      offer_item(ibf_pkg::OP_FILL, 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    reg_writes++;
  endtask

  task automatic program_regs(input ibf_pkg::cfg_t v, input logic only_rep);
    drain();
    put_reg(ibf_pkg::CFG_REP_BYTES, v.period_bytes);
    if (!only_rep) begin
      put_reg(ibf_pkg::CFG_USE_PRE, {15'd0, v.preamble_en});
      put_reg(ibf_pkg::CFG_SWAP, {15'd0, v.swap_bytes});
      put_reg(ibf_pkg::CFG_INFO, v.burst_info);
      put_reg(ibf_pkg::CFG_LENGTH, v.burst_length);
      cur_cfg = v;
    end else begin
      cur_cfg.period_bytes = v.period_bytes;
    end
    cfg_valid_i <= 1'b0;
  endtask

  // one frame plus its padding, sized from the current setting; random items alone when no period is set
  task automatic burst_cycle();
    int lim;
    int pre;
    int cap;
    int n;
    int used;
    lim = int'(cur_cfg.period_bytes & 16'hFFFE);
    pre = cur_cfg.preamble_en ? int'(ibf_pkg::PREAMBLE_BYTES) : 0;
    if (lim == 0) begin
      repeat ($urandom_range(1, 3)) offer_item(1'($urandom), 8'($urandom), 1'($urandom));
    end else begin
      if ($urandom_range(0, 7) == 0) offer_item(ibf_pkg::OP_FILL, 8'($urandom), 1'($urandom));
      cap = lim - pre;
      if (cap < 2 || $urandom_range(0, 5) == 0) begin
        n = (cap < 0 ? 0 : cap) + $urandom_range(1, 4);
      end else begin
        n = $urandom_range(1, cap);
      end
      send_frame(n);
      used = ((n + 1) / 2) * 2 + pre;
      if (used <= lim) send_fills((lim - used) / 2, $urandom_range(0, 5) == 0);
      if ($urandom_range(0, 7) == 0) drain();
    end
  endtask

  task automatic reconfigure();
    ibf_pkg::cfg_t nxt;
    int            r;
    r   = $urandom_range(0, 9);
    nxt = cur_cfg;
    if (r == 0) begin
      nxt.period_bytes = 16'd0;
      program_regs(nxt, 1'b1);
    end else if (r == 1) begin
      // long period, then shrink it while padding is under way
      nxt.period_bytes = 16'hFFFE;
      nxt.preamble_en  = 1'($urandom);
      program_regs(nxt, 1'b0);
      send_frame($urandom_range(1, 4));
      send_fills(2, 1'b0);
      nxt.period_bytes = 16'($urandom_range(1, 3) * 2);
      program_regs(nxt, 1'b1);
      offer_item(ibf_pkg::OP_FILL, 8'($urandom), 1'($urandom));
    end else begin
      nxt.period_bytes = 16'($urandom_range(1, 24) * 2 + (r == 2 ? 1 : 0));
      nxt.preamble_en  = 1'($urandom);
      nxt.swap_bytes   = 1'($urandom);
      nxt.burst_info   = 16'($urandom);
      nxt.burst_length = 16'($urandom);
      program_regs(nxt, 1'b0);
    end
  endtask

  initial begin : stimulus
    ibf_pkg::cfg_t nxt;
    int            base_items;
    cur_cfg = '{period_bytes: 16'd0, preamble_en: 1'b1, swap_bytes: 1'b1,
                burst_info: 16'd0, burst_length: 16'd0};
    while (!rst_ni) @(posedge clk_i);
    @(posedge clk_i);

    // unconfigured period length
    offer_item(ibf_pkg::OP_BYTE, 8'h00, 1'b0);
    offer_item(ibf_pkg::OP_FILL, 8'hFF, 1'b1);

    nxt = '{period_bytes: 16'd16, preamble_en: 1'b1, swap_bytes: 1'b0,
            burst_info: 16'hFFFF, burst_length: 16'h0000};
    program_regs(nxt, 1'b0);
    offer_item(ibf_pkg::OP_FILL, 8'h00, 1'b0);
    offer_item(ibf_pkg::OP_BYTE, 8'hFF, 1'b0);
    offer_item(ibf_pkg::OP_BYTE, 8'h00, 1'b0);
    offer_item(ibf_pkg::OP_BYTE, 8'h5A, 1'b1);
    offer_item(ibf_pkg::OP_FILL, 8'h00, 1'b0);
    offer_item(ibf_pkg::OP_BYTE, 8'h80, 1'b0);
    offer_item(ibf_pkg::OP_FILL, 8'hFF, 1'b1);
    offer_item(ibf_pkg::OP_FILL, 8'h00, 1'b0);

    // odd length, preamble plus two words fills it exactly
    nxt.period_bytes = 16'd13;
    nxt.swap_bytes   = 1'b1;
    nxt.burst_info   = 16'h0000;
    nxt.burst_length = 16'hFFFF;
    program_regs(nxt, 1'b0);
    send_frame(4);
    send_frame(6);

    // preamble plus first word does not fit
    nxt.period_bytes = 16'd8;
    program_regs(nxt, 1'b1);
    send_frame(2);

    nxt.period_bytes = 16'hFFFE;
    nxt.preamble_en  = 1'b0;
    program_regs(nxt, 1'b0);
    send_frame(1);
    offer_item(ibf_pkg::OP_FILL, 8'h00, 1'b0);
    nxt.period_bytes = 16'd4;
    program_regs(nxt, 1'b1);
    offer_item(ibf_pkg::OP_FILL, 8'hFF, 1'b1);
    base_items = items_sent;

    nxt = '{period_bytes: 16'd40, preamble_en: 1'b1, swap_bytes: 1'($urandom),
            burst_info: 16'($urandom), burst_length: 16'($urandom)};
    program_regs(nxt, 1'b0);
    hold_req = 1'b1;
    burst_cycle();
    burst_cycle();
    while (items_sent < base_items + RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) reconfigure();
      burst_cycle();
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (16) @(posedge clk_i);
    $display("summary: %0d input items in %0d frames, %0d register writes",
             items_sent, frames_sent, reg_writes);
    $display("summary: %0d burst words checked, output held off once for %0d cycles",
             checked, HOLD_CYCLES);
    if (fail_count == 0 && outstanding == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
